>>> src/encoder_angle_unwrap_defines.svh
// Assertion macros for the encoder angle unwrap block.
// Included by the RTL files that carry concurrent assertions.
`ifndef ENCODER_ANGLE_UNWRAP_DEFINES_SVH
`define ENCODER_ANGLE_UNWRAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EAU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eau assertion failed");

// Next-cycle implication, checked outside reset.
`define EAU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eau assertion failed");

`endif

>>> src/eau_pkg.sv
// Shared constants and types for the encoder angle unwrap block.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package eau_pkg;

  localparam int RAW_BITS    = 14;  // raw angle width delivered by the sensor
  localparam int ANGLE_W     = 16;
  localparam int POS_W       = 32;
  localparam int WORD_W      = 16;
  localparam int ANGLE_BITS_W = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ANGLE_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REVERSE    = CFG_IDX_W'(1);

  localparam logic [ANGLE_BITS_W-1:0] ANGLE_BITS_RESET = ANGLE_BITS_W'(14);
  localparam logic                    REVERSE_RESET    = 1'b1;
  localparam logic [ANGLE_BITS_W-1:0] ANGLE_BITS_MAX   = ANGLE_BITS_W'(ANGLE_W);
  localparam logic [ANGLE_BITS_W-1:0] ANGLE_BITS_MIN   = ANGLE_BITS_W'(1);

  localparam logic [ANGLE_W-1:0] ANGLE_OUT_MASK = 16'hFFF8;

  typedef struct packed {
    logic [ANGLE_BITS_W-1:0] angle_bits;
    logic                    reverse_direction;
  } eau_cfg_t;

endpackage

`default_nettype wire

>>> src/eau_if.sv
// Valid/ready channel interfaces for sensor samples and unwrapped results.
// Depends on eau_pkg for field widths.
`default_nettype none

interface eau_sample_if;
  import eau_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   rx_first_word;
  logic [WORD_W-1:0]   rx_second_word;

  modport source (output valid, output rx_first_word, output rx_second_word, input ready);
  modport sink   (input valid, input rx_first_word, input rx_second_word, output ready);
endinterface

interface eau_result_if;
  import eau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ANGLE_W-1:0]       angle_out;
  logic signed [POS_W-1:0]  turn_position;

  modport source (output valid, output angle_out, output turn_position, input ready);
  modport sink   (input valid, input angle_out, input turn_position, output ready);
endinterface

`default_nettype wire

>>> src/eau_scale.sv
// Raw angle extraction from the two received words, scaling to 16 bits
// and optional direction reversal. Depends on eau_pkg.
`default_nettype none

module eau_scale (
  input  wire eau_pkg::eau_cfg_t               cfg,
  input  wire logic [eau_pkg::WORD_W-1:0]      rx_first_word,
  input  wire logic [eau_pkg::WORD_W-1:0]      rx_second_word,
  output logic      [eau_pkg::ANGLE_W-1:0]     angle
);
  import eau_pkg::*;

  logic [WORD_W-1:0]       raw_word;
  logic [RAW_BITS-1:0]     raw;
  logic [ANGLE_W-1:0]      raw_ext;
  logic [ANGLE_BITS_W-1:0] bits_eff;
  logic [3:0]              shift;
  logic [ANGLE_W-1:0]      scaled;

  assign raw_word = {rx_first_word[7:0], rx_second_word[15:8]};
  assign raw      = raw_word[WORD_W-1 -: RAW_BITS];
  assign raw_ext  = ANGLE_W'(raw);

  // Out-of-range resolutions clamp to 1..16.
  always_comb begin
    if (cfg.angle_bits inside {[ANGLE_BITS_MAX : {ANGLE_BITS_W{1'b1}}]}) begin
      bits_eff = ANGLE_BITS_MAX;
    end else if (cfg.angle_bits == '0) begin
      bits_eff = ANGLE_BITS_MIN;
    end else begin
      bits_eff = cfg.angle_bits;
    end
  end

  assign shift  = 4'(ANGLE_BITS_MAX - bits_eff);
  assign scaled = raw_ext << shift;
  assign angle  = cfg.reverse_direction ? (ANGLE_W'(0) - scaled) : scaled;

endmodule

`default_nettype wire

>>> src/eau_unwrap.sv
// Unwrap state (previous angle, seeded flag, position) and result register.
// Depends on eau_pkg, eau_if and encoder_angle_unwrap_defines.svh.
`default_nettype none
`include "encoder_angle_unwrap_defines.svh"

module eau_unwrap (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          stage_valid,
  input  wire logic [eau_pkg::ANGLE_W-1:0]   angle,
  output logic                               take,
  eau_result_if.source                       result
);
  import eau_pkg::*;

  logic                seeded;
  logic [ANGLE_W-1:0]  prev_angle;
  logic [POS_W-1:0]    pos_sum;
  logic                out_valid;

  logic [ANGLE_W-1:0]  step;
  logic [POS_W-1:0]    step_ext;
  logic [POS_W-1:0]    pos_sum_next;

  // Mod-2^16 difference read as signed is exactly the wrapped step.
  assign step         = seeded ? (angle - prev_angle) : '0;
  assign step_ext     = {{(POS_W-ANGLE_W){step[ANGLE_W-1]}}, step};
  assign pos_sum_next = pos_sum + step_ext;

  assign take = stage_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded     <= 1'b0;
      prev_angle <= '0;
      pos_sum    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        seeded     <= 1'b1;
        prev_angle <= angle;
        pos_sum    <= pos_sum_next;
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.angle_out     = prev_angle & ANGLE_OUT_MASK;
  assign result.turn_position = $signed(pos_sum);

  `EAU_ASSERT_NXT(a_first_no_move, clk, rst, take && !seeded, pos_sum == $past(pos_sum))
  `EAU_ASSERT_NXT(a_pos_adds_step, clk, rst, take, pos_sum == $past(pos_sum) + $past(step_ext))
  `EAU_ASSERT_NXT(a_seeded_sticks, clk, rst, seeded, seeded)
  `EAU_ASSERT_NXT(a_take_shows, clk, rst, take, out_valid)
  `EAU_ASSERT_IMP(a_valid_seeded, clk, rst, out_valid, seeded)

endmodule

`default_nettype wire

>>> src/encoder_angle_unwrap.sv
// A sample passes the input register, then the result register; a low result ready holds both.
// Throughput: one sample per cycle if result ready; input register refills as result loads.
// The critical path is the scale shift, 16-bit difference and 32-bit position add.
// Reset (synchronous, rst high): angle_bits 14, reverse on, position zero, and the
// first sample afterwards seeds the previous angle without moving the position.
// Top level: config registers, input register, scaling and unwrap stage.
`default_nettype none

module encoder_angle_unwrap (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [eau_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [eau_pkg::CFG_DATA_W-1:0]    cfg_data,
  eau_sample_if.sink                             sample,
  eau_result_if.source                           result
);
  import eau_pkg::*;

  eau_cfg_t            cfg;
  logic                s1_valid;
  logic [WORD_W-1:0]   s1_first;
  logic [WORD_W-1:0]   s1_second;
  logic [ANGLE_W-1:0]  angle;
  logic                take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_bits        <= ANGLE_BITS_RESET;
      cfg.reverse_direction <= REVERSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_ANGLE_BITS: cfg.angle_bits        <= cfg_data[ANGLE_BITS_W-1:0];
        CFG_IDX_REVERSE:    cfg.reverse_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sample.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_first  <= sample.rx_first_word;
      s1_second <= sample.rx_second_word;
    end
  end

  eau_scale u_scale (
    .cfg            (cfg),
    .rx_first_word  (s1_first),
    .rx_second_word (s1_second),
    .angle          (angle)
  );

  eau_unwrap u_unwrap (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (s1_valid),
    .angle       (angle),
    .take        (take),
    .result      (result)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for encoder_angle_unwrap: random sensor word pairs,
// random valid/ready idling, and an in-bench predictor of angle and position.
// Depends on eau_pkg and the eau_sample_if / eau_result_if interfaces.

module testbench;
  import eau_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] rx_first_word;
    logic [WORD_W-1:0] rx_second_word;
  } sensor_words_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]       angle_out;
    logic signed [POS_W-1:0]  turn_position;
  } unwrap_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  eau_sample_if sample_ch ();
  eau_result_if result_ch ();

  encoder_angle_unwrap u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  always #10 clk = ~clk;

  sensor_words_t  pending_words[$];
  unwrap_result_t expected_results[$];
  int             mismatch_count = 0;
  logic           idle_on = 1'b1;
  logic           in_fired = 1'b0;
  logic           out_fired = 1'b0;
  int unsigned    send_gap = 0;
  int unsigned    recv_stall = 0;

  // Predictor state and its copy of the configuration
  logic [ANGLE_BITS_W-1:0] cur_angle_bits = ANGLE_BITS_RESET;
  logic                    cur_reverse    = REVERSE_RESET;
  logic                    seeded         = 1'b0;
  logic [ANGLE_W-1:0]      prev_angle     = '0;
  logic signed [POS_W-1:0] pos_sum        = '0;

  function automatic logic [ANGLE_W-1:0] scaled_angle(logic [WORD_W-1:0] w0,
                                                      logic [WORD_W-1:0] w1);
    logic [15:0]  raw_word;
    int unsigned  raw;
    int unsigned  nbits;
    logic [ANGLE_W-1:0] a;
    raw_word = {w0[7:0], w1[15:8]};
    raw = (raw_word >> (WORD_W - RAW_BITS)) & ((1 << RAW_BITS) - 1);
    nbits = 32'(cur_angle_bits);
    if (nbits > ANGLE_W) nbits = ANGLE_W;
    if (nbits < 1) nbits = 1;
    a = ANGLE_W'(raw << (ANGLE_W - nbits));
    if (cur_reverse) a = -a;
    return a;
  endfunction

  function automatic unwrap_result_t unwrap_sample(logic [WORD_W-1:0] w0,
                                                   logic [WORD_W-1:0] w1);
    logic [ANGLE_W-1:0] ang;
    int                 step;
    unwrap_result_t     res;
    ang = scaled_angle(w0, w1);
    if (!seeded) begin
      prev_angle = ang;
      seeded = 1'b1;
    end
    step = int'(ang) - int'(prev_angle);
    if (step >= 32768) step -= 65536;
    if (step < -32768) step += 65536;
    pos_sum = pos_sum + step;
    prev_angle = ang;
    res.angle_out = ang & ANGLE_OUT_MASK;
    res.turn_position = pos_sum;
    return res;
  endfunction

  // Packs a raw angle into the two words; unused bits get random filler
  function automatic sensor_words_t make_words(int unsigned raw);
    logic [15:0]   word;
    sensor_words_t w;
    word = 16'((raw << (WORD_W - RAW_BITS)) |
               ($urandom & ((1 << (WORD_W - RAW_BITS)) - 1)));
    w.rx_first_word  = {8'($urandom), word[15:8]};
    w.rx_second_word = {word[7:0], 8'($urandom)};
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Sample driver
  always @(negedge clk) begin : sample_drive
    sensor_words_t item;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!sample_ch.valid || in_fired) begin
      if (send_gap != 0) begin
        sample_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() != 0) begin
        item = pending_words.pop_front();
        sample_ch.rx_first_word  <= item.rx_first_word;
        sample_ch.rx_second_word <= item.rx_second_word;
        sample_ch.valid <= 1'b1;
        send_gap <= idle_on ? $urandom_range(0, 4) : 0;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready with random stalls
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else if (!result_ch.ready || out_fired) begin
      if (recv_stall != 0) begin
        result_ch.ready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        result_ch.ready <= 1'b1;
        recv_stall <= idle_on ? $urandom_range(0, 4) : 0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    unwrap_result_t want;
    in_fired  <= !rst && sample_ch.valid && sample_ch.ready;
    out_fired <= !rst && result_ch.valid && result_ch.ready;
    if (!rst && sample_ch.valid && sample_ch.ready)
      expected_results.push_back(unwrap_sample(sample_ch.rx_first_word,
                                               sample_ch.rx_second_word));
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", '0, 32'(result_ch.angle_out));
      end else begin
        want = expected_results.pop_front();
        if (result_ch.angle_out !== want.angle_out)
          report_mismatch("angle_out", 32'(want.angle_out), 32'(result_ch.angle_out));
        if (result_ch.turn_position !== want.turn_position)
          report_mismatch("turn_position", want.turn_position, result_ch.turn_position);
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || sample_ch.valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_IDX_ANGLE_BITS) cur_angle_bits = data;
    else cur_reverse = data[0];
  endtask

  task automatic set_config(int unsigned nbits, logic rev);
    write_reg(CFG_IDX_ANGLE_BITS, CFG_DATA_W'(nbits));
    // upper data bits are don't-care for the direction flag
    write_reg(CFG_IDX_REVERSE, CFG_DATA_W'(($urandom_range(0, 15) << 1) | rev));
  endtask

  task automatic queue_random(int n, inout int unsigned last_raw);
    sensor_words_t w;
    int unsigned   pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        w.rx_first_word  = 16'($urandom);
        w.rx_second_word = 16'($urandom);
        last_raw = ({w.rx_first_word[7:0], w.rx_second_word[15:8]} >>
                    (WORD_W - RAW_BITS)) & ((1 << RAW_BITS) - 1);
      end else begin
        if (pick < 8)
          last_raw = (last_raw + $urandom_range(0, 80) - 40) & ((1 << RAW_BITS) - 1);
        else  // close to half a turn away
          last_raw = ((last_raw ^ (1 << (RAW_BITS - 1))) + $urandom_range(0, 2) - 1)
                     & ((1 << RAW_BITS) - 1);
        w = make_words(last_raw);
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    int unsigned   bits_plan[9] = '{16, 1, 0, 17, 31, 8, 12, 5, 14};
    logic          rev_plan[9]  = '{0, 1, 0, 1, 0, 1, 0, 1, 1};
    int unsigned   directed_raw[12] = '{'h1234, 'h0000, 'h3FFF, 'h0000, 'h2000, 'h0000,
                                        'h2000, 'h1FFF, 'h3FFF, 'h0001, 'h2001, 'h0100};
    int unsigned   last_raw = 0;
    sensor_words_t w;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.rx_first_word = '0;
    sample_ch.rx_second_word = '0;
    result_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset config, first sample seeds, word extremes, half-turn steps
    w.rx_first_word = 16'h0000; w.rx_second_word = 16'h0000; pending_words.push_back(w);
    w.rx_first_word = 16'hFFFF; w.rx_second_word = 16'hFFFF; pending_words.push_back(w);
    w.rx_first_word = 16'h00FF; w.rx_second_word = 16'hFF00; pending_words.push_back(w);
    w.rx_first_word = 16'hFF00; w.rx_second_word = 16'h00FF; pending_words.push_back(w);
    foreach (directed_raw[i]) pending_words.push_back(make_words(directed_raw[i]));
    wait_drained();

    // Half-turn spin back to back: after the first sample every step is -32768
    idle_on = 1'b0;
    for (int i = 0; i < 16; i++)
      pending_words.push_back(make_words((i % 2) ? (1 << (RAW_BITS - 1)) : 0));
    wait_drained();
    idle_on = 1'b1;
    queue_random(42, last_raw);
    wait_drained();

    foreach (bits_plan[i]) begin
      set_config(bits_plan[i], rev_plan[i]);
      idle_on = ($urandom_range(0, 3) != 0);
      queue_random(42, last_raw);
      wait_drained();
    end

    repeat (2) begin
      set_config($urandom_range(0, 31), 1'($urandom));
      idle_on = 1'b1;
      queue_random(42, last_raw);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
